// ===== rtl/sft_pkg.sv =====
// Package for the sparse triplet fast transpose block.
// Holds payload structs, controller/datapath command and status types, and
// configuration register codes. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sft_pkg;

  localparam int ROW_W      = 5;
  localparam int COL_W      = 5;
  localparam int VAL_W      = 32;
  localparam int TOTAL_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 2'd1;

  localparam logic [CFG_DATA_W-1:0] NUM_COLS_RESET = 6'd32;

  typedef struct packed {
    logic                    has_entry;
    logic [ROW_W-1:0]        in_row;
    logic [COL_W-1:0]        in_col;
    logic signed [VAL_W-1:0] in_value;
    logic                    last_entry;
  } in_t;

  typedef struct packed {
    logic [ROW_W-1:0]        out_row;
    logic [COL_W-1:0]        out_col;
    logic signed [VAL_W-1:0] out_value;
    logic [TOTAL_W-1:0]      total_entries;
    logic                    entry_valid;
    logic                    dropped_any;
    logic                    last_result;
  } out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;      // input request accepted this cycle
    logic idx_clr;   // reset the shared index counter
    logic prefix;    // one step of the start position scan
    logic sc_rd;     // read one kept entry for the scatter pass
    logic em_rd;     // read one transposed entry
    logic em_ld;     // load the read entry into the output register
    logic em_empty;  // load the empty-matrix result
    logic clear;     // clear the matrix state
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic total_zero;
    logic idx_cols_end;
    logic idx_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/sft_stream_if.sv =====
// Valid/ready channel interface for the sparse triplet fast transpose block.
// The payload type is a parameter; the payload structs come from sft_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sft_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/sft_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// Stand-alone; used for the entry store and the transposed store.
`timescale 1ns / 1ps
`default_nettype none

module sft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/sft_ctrl.sv =====
// Controller state machine of the sparse triplet fast transpose block.
// Sequences load, prefix, scatter and emit passes; uses sft_pkg types.
`timescale 1ns / 1ps
`default_nettype none

module sft_ctrl
  import sft_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic in_last_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FIN    = 3'd1;
  localparam logic [2:0] S_EMPTY  = 3'd2;
  localparam logic [2:0] S_PREFIX = 3'd3;
  localparam logic [2:0] S_SCAT   = 3'd4;
  localparam logic [2:0] S_SC_END = 3'd5;
  localparam logic [2:0] S_EM_RD  = 3'd6;
  localparam logic [2:0] S_EM_LD  = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (in_last_i) begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (sts_i.total_zero) begin
          state_d = S_EMPTY;
        end else begin
          cmd_o.idx_clr = 1'b1;
          state_d       = S_PREFIX;
        end
      end
      S_EMPTY: begin
        if (sts_i.out_free) begin
          cmd_o.em_empty = 1'b1;
          cmd_o.clear    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_PREFIX: begin
        cmd_o.prefix = 1'b1;
        if (sts_i.idx_cols_end) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = S_SCAT;
        end
      end
      S_SCAT: begin
        cmd_o.sc_rd = 1'b1;
        if (sts_i.idx_last) begin
          state_d = S_SC_END;
        end
      end
      S_SC_END: begin
        // The final scatter write completes in this cycle.
        cmd_o.idx_clr = 1'b1;
        state_d       = S_EM_RD;
      end
      S_EM_RD: begin
        if (sts_i.out_free) begin
          cmd_o.em_rd = 1'b1;
          state_d     = S_EM_LD;
        end
      end
      S_EM_LD: begin
        cmd_o.em_ld = 1'b1;
        if (sts_i.idx_last) begin
          cmd_o.clear = 1'b1;
          state_d     = S_IDLE;
        end else begin
          state_d = S_EM_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sft_datapath.sv =====
// Datapath of the sparse triplet fast transpose block: column counters,
// entry and transposed stores, index counter and output register.
// Uses sft_pkg types and two sft_ram instances.
`timescale 1ns / 1ps
`default_nettype none

module sft_datapath
  import sft_pkg::*;
#(
  parameter int MAX_DIM    = 32,
  parameter int MAX_TERMS  = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cmd_t                  cmd_i,
  output sts_t                       sts_o,
  input  wire in_t                   in_data_i,
  input  wire logic                  cfg_we_i,
  input  wire cfg_t                  cfg_data_i,
  output logic                       out_valid_o,
  output out_t                       out_data_o,
  input  wire logic                  out_ready_i
);

  // Column indexes are five bits wide, so at most 32 columns can be used.
  localparam int COLS   = (MAX_DIM < 32) ? MAX_DIM : 32;
  localparam int CIDX_W = $clog2(COLS);
  localparam int TADR_W = $clog2(MAX_TERMS);
  localparam int IDX_W  = $clog2(MAX_TERMS + 1);
  localparam int IX_W   = (IDX_W > CIDX_W) ? IDX_W : CIDX_W;
  localparam int SW     = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;
  localparam int EW     = ROW_W + COL_W + SW;

  logic [CFG_DATA_W-1:0] num_cols_q;
  logic [IDX_W-1:0]      total_q;
  logic                  drop_q;
  logic [IDX_W-1:0]      pos_q;
  logic [IX_W-1:0]       idx_q;
  logic                  sc_vld_q;
  logic [IDX_W-1:0]      cnt_q [COLS];
  logic                  out_valid_q;
  out_t                  out_q;

  logic [CIDX_W-1:0] cidx;
  logic [IDX_W-1:0]  cnt_rd;
  logic              col_ok;
  logic              keep;
  logic [IX_W:0]     idx_p1;
  logic              idx_last;
  logic              out_free;

  logic [EW-1:0]     ent_rdata;
  logic [ROW_W-1:0]  ent_row;
  logic [COL_W-1:0]  ent_col;
  logic [EW-1:0]     ts_rdata;

  // The num_rows register is accepted but no logic depends on it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cols_q <= NUM_COLS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_data_i.index)
        REG_NUM_COLS: num_cols_q <= cfg_data_i.data;
        REG_NUM_ROWS: ;
        default: ;
      endcase
    end
  end

  assign col_ok = ({1'b0, in_data_i.in_col} < num_cols_q) && (32'(in_data_i.in_col) < MAX_DIM);
  assign keep   = in_data_i.has_entry && col_ok && (total_q < IDX_W'(MAX_TERMS));

  assign ent_row = ent_rdata[EW-1 -: ROW_W];
  assign ent_col = ent_rdata[EW-ROW_W-1 -: COL_W];

  // One read of the column counters per cycle, addressed by the active pass.
  always_comb begin
    if (cmd_i.prefix) begin
      cidx = idx_q[CIDX_W-1:0];
    end else if (sc_vld_q) begin
      cidx = ent_col[CIDX_W-1:0];
    end else begin
      cidx = in_data_i.in_col[CIDX_W-1:0];
    end
  end
  assign cnt_rd = cnt_q[cidx];

  assign idx_p1   = {1'b0, idx_q} + 1'b1;
  assign idx_last = (idx_p1 == (IX_W + 1)'(total_q));
  assign out_free = !out_valid_q || out_ready_i;

  // Counters become start positions after the prefix pass and advance
  // as entries are scattered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < COLS; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (cmd_i.clear) begin
      for (int i = 0; i < COLS; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (cmd_i.prefix) begin
      cnt_q[cidx] <= pos_q;
    end else if (sc_vld_q || (cmd_i.take && keep)) begin
      cnt_q[cidx] <= cnt_rd + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= '0;
      drop_q   <= 1'b0;
      pos_q    <= '0;
      idx_q    <= '0;
      sc_vld_q <= 1'b0;
    end else begin
      sc_vld_q <= cmd_i.sc_rd;
      if (cmd_i.clear) begin
        total_q <= '0;
        drop_q  <= 1'b0;
        pos_q   <= '0;
      end else if (cmd_i.take) begin
        if (keep) begin
          total_q <= total_q + 1'b1;
        end else if (in_data_i.has_entry) begin
          drop_q <= 1'b1;
        end
      end else if (cmd_i.prefix) begin
        pos_q <= pos_q + cnt_rd;
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.prefix || cmd_i.sc_rd || cmd_i.em_ld) begin
        idx_q <= idx_p1[IX_W-1:0];
      end
    end
  end

  sft_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_TERMS)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.take && keep),
    .waddr_i (total_q[TADR_W-1:0]),
    .wdata_i ({in_data_i.in_row, in_data_i.in_col, in_data_i.in_value[SW-1:0]}),
    .re_i    (cmd_i.sc_rd),
    .raddr_i (idx_q[TADR_W-1:0]),
    .rdata_o (ent_rdata)
  );

  // Row and column swap on the way into the transposed store.
  sft_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_TERMS)
  ) u_trans_ram (
    .clk_i   (clk_i),
    .we_i    (sc_vld_q),
    .waddr_i (cnt_rd[TADR_W-1:0]),
    .wdata_i ({ent_col, ent_row, ent_rdata[SW-1:0]}),
    .re_i    (cmd_i.em_rd),
    .raddr_i (idx_q[TADR_W-1:0]),
    .rdata_o (ts_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.em_ld || cmd_i.em_empty) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.em_ld) begin
      out_q.out_row       <= ts_rdata[EW-1 -: ROW_W];
      out_q.out_col       <= ts_rdata[EW-ROW_W-1 -: COL_W];
      out_q.out_value     <= signed'(VAL_W'(ts_rdata[SW-1:0]));
      out_q.total_entries <= TOTAL_W'(total_q);
      out_q.entry_valid   <= 1'b1;
      out_q.dropped_any   <= drop_q;
      out_q.last_result   <= idx_last;
    end else if (cmd_i.em_empty) begin
      out_q.out_row       <= '0;
      out_q.out_col       <= '0;
      out_q.out_value     <= '0;
      out_q.total_entries <= '0;
      out_q.entry_valid   <= 1'b0;
      out_q.dropped_any   <= drop_q;
      out_q.last_result   <= 1'b1;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_q;
  assign sts_o.total_zero   = (total_q == '0);
  assign sts_o.idx_cols_end = (idx_q == IX_W'(COLS - 1));
  assign sts_o.idx_last     = idx_last;
  assign sts_o.out_free     = out_free;

  // The prefix scan must account for every kept entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.sc_rd && (idx_q == '0)) |-> (pos_q == total_q))
    else $error("start positions do not sum to the entry total");

  // Scatter writes stay inside the kept range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sc_vld_q |-> (cnt_rd < total_q))
    else $error("scatter position beyond the entry total");

  // A result is loaded only when the output register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.em_ld || cmd_i.em_empty) |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten");

  // Loading never overlaps the scatter pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take |-> !sc_vld_q)
    else $error("request taken during scatter");

endmodule

`default_nettype wire

// ===== rtl/sparse_triplet_fast_transpose_top.sv =====
// Top level of the sparse triplet fast transpose block.
// Depends on sft_pkg, sft_stream_if, sft_ctrl, sft_datapath and sft_ram.
//
// The block takes nonzero entries of a sparse matrix as row, column, value
// triplets, one per input request, and on the request marked last it emits
// the transposed matrix, grouped by original column, one result request per
// kept entry (or a single empty result when nothing was kept). While loading,
// the input stays ready, so triplets can follow back to back. After the last
// request the block decides whether any entry was kept, then scans the column
// counters once, one column per step, then scatters the kept entries
// through the entry RAM one at a time, and finally reads the transposed
// RAM one result at a time, waiting while the sink holds ready low. The
// input channel accepts requests only between matrices; it reopens as soon
// as the final result sits in the output register. Column counters live in
// flip-flops and are cleared at once, so there is no clearing pass after
// reset. Entries whose column is not below min(num_cols, MAX_DIM), or that
// arrive when MAX_TERMS entries are already kept, are dropped and raise
// dropped_any on every result of that matrix. The num_rows register is
// accepted but affects nothing. Configuration writes are always accepted
// and must only be issued while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module sparse_triplet_fast_transpose_top
  import sft_pkg::*;
#(
  parameter int MAX_DIM    = 32,
  parameter int MAX_TERMS  = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  sft_stream_if.sink   in_i,
  sft_stream_if.source out_o,
  sft_stream_if.sink   cfg_i
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic out_valid;
  out_t out_data;

  // The controller owns the input handshake; the datapath owns the output.
  sft_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.payload.last_entry),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sft_datapath #(
    .MAX_DIM    (MAX_DIM),
    .MAX_TERMS  (MAX_TERMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_i.payload),
    .cfg_we_i    (cfg_i.valid),
    .cfg_data_i  (cfg_i.payload),
    .out_valid_o (out_valid),
    .out_data_o  (out_data),
    .out_ready_i (out_o.ready)
  );

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid;
  assign out_o.payload = out_data;
  // Register writes complete in the cycle they are presented.
  assign cfg_i.ready   = 1'b1;

endmodule

`default_nettype wire
